[hw/rtl/pfla_pkg.sv]
// Shared types and codes for the page free-list allocator.
`timescale 1ns / 1ps

package pfla_pkg;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned CFG_W    = 13;
	localparam int unsigned OADDR_W  = 24;
	localparam int unsigned OCOUNT_W = 13;
	localparam int unsigned ADDR_W   = 64;
	localparam int unsigned PHYS_W   = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2
	} cmd_code_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_BAD_FREE = 2'd2,
		STAT_NOT_INIT = 2'd3
	} status_code_t;

	typedef enum logic {
		CFG_TOTAL    = 1'b0,
		CFG_RESERVED = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_INIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic sweep;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
	} dp_status_t;

endpackage

[hw/rtl/pfla_ctrl.sv]
// Controller state machine for the page free-list allocator.
`timescale 1ns / 1ps

module pfla_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pfla_pkg::CMD_W-1:0]   command,
	input  pfla_pkg::dp_status_t         dp_stat,
	output pfla_pkg::ctrl_cmd_t          ctl,
	output logic                         busy
);
	import pfla_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (command == CMD_INIT) ? S_INIT : S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			S_INIT: begin
				if (dp_stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.accept = (state_q == S_IDLE) && start;
		ctl.exec   = (state_q == S_EXEC);
		ctl.sweep  = (state_q == S_INIT);
		busy       = (state_q != S_IDLE);
	end

endmodule

[hw/rtl/pfla_datapath.sv]
// Datapath: config registers, free queue, in-use bits, pointers and result registers.
`timescale 1ns / 1ps

module pfla_datapath #(
	parameter int unsigned MAX_PAGES  = 4096,
	parameter int unsigned PAGE_SHIFT = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pfla_pkg::ctrl_cmd_t             ctl,
	output pfla_pkg::dp_status_t            dp_stat,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [pfla_pkg::CFG_W-1:0]      cfg_data,
	input  logic [pfla_pkg::CMD_W-1:0]      command,
	input  logic [pfla_pkg::ADDR_W-1:0]     free_address,
	output logic                            done,
	output logic [pfla_pkg::OADDR_W-1:0]    page_address,
	output logic [pfla_pkg::STAT_W-1:0]     status,
	output logic [pfla_pkg::OCOUNT_W-1:0]   free_count
);
	import pfla_pkg::*;

	localparam int unsigned PW  = $clog2(MAX_PAGES);
	localparam int unsigned CW  = $clog2(MAX_PAGES + 1);
	localparam int unsigned PGW = PHYS_W - PAGE_SHIFT;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(MAX_PAGES - 1)) begin
			r = '0;
		end else begin
			r = p + PW'(1);
		end
		return r;
	endfunction

	logic [CFG_W-1:0] total_cfg_q;
	logic [CFG_W-1:0] reserved_cfg_q;
	logic [CFG_W-1:0] eff_total;
	logic [CFG_W-1:0] eff_res;

	logic [CMD_W-1:0] cmd_q;
	logic [PGW-1:0]   page_q;
	logic [PW-1:0]    sweep_q;
	logic [PW-1:0]    head_q, head_d;
	logic [PW-1:0]    tail_q, tail_d;
	logic [CW-1:0]    count_q, count_d;
	logic             ready_q, ready_d;

	logic             in_use_mem [MAX_PAGES];
	logic [PW-1:0]    queue_mem  [MAX_PAGES];
	logic             in_use_rd_q;
	logic [PW-1:0]    queue_rd_q;

	logic             iu_we;
	logic [PW-1:0]    iu_waddr;
	logic             iu_wdata;
	logic             q_we;
	logic [PW-1:0]    q_wdata;

	logic             free_pg;
	logic             res_valid;
	logic [OADDR_W-1:0] res_addr;
	status_code_t     res_status;
	logic [63:0]      alloc_addr;
	logic [31:0]      count_wide;

	logic                done_q;
	logic [OADDR_W-1:0]  addr_q;
	logic [STAT_W-1:0]   status_q;
	logic [OCOUNT_W-1:0] fcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_cfg_q    <= CFG_W'(4096);
			reserved_cfg_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TOTAL) begin
				total_cfg_q <= cfg_data;
			end else begin
				reserved_cfg_q <= cfg_data;
			end
		end
	end

	// Clamp total to the store depth, then reserved to the clamped total.
	always_comb begin
		if (32'(total_cfg_q) > 32'(MAX_PAGES)) begin
			eff_total = CFG_W'(MAX_PAGES);
		end else begin
			eff_total = total_cfg_q;
		end
		eff_res = (reserved_cfg_q > eff_total) ? eff_total : reserved_cfg_q;
	end

	assign dp_stat.sweep_last = ctl.sweep && (sweep_q == PW'(MAX_PAGES - 1));

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		ready_d    = ready_q;
		iu_we      = 1'b0;
		iu_waddr   = sweep_q;
		iu_wdata   = 1'b1;
		q_we       = 1'b0;
		q_wdata    = sweep_q;
		res_valid  = 1'b0;
		res_addr   = '0;
		res_status = STAT_OK;
		alloc_addr = 64'(queue_rd_q) << PAGE_SHIFT;
		free_pg    = (32'(sweep_q) >= 32'(eff_res)) && (32'(sweep_q) < 32'(eff_total));

		if (ctl.accept && (command == CMD_INIT)) begin
			head_d  = '0;
			tail_d  = '0;
			count_d = '0;
		end

		if (ctl.sweep) begin
			iu_we    = 1'b1;
			iu_waddr = sweep_q;
			iu_wdata = !free_pg;
			if (free_pg) begin
				q_we    = 1'b1;
				q_wdata = sweep_q;
				tail_d  = ptr_inc(tail_q);
				count_d = count_q + CW'(1);
			end
			if (dp_stat.sweep_last) begin
				ready_d   = 1'b1;
				res_valid = 1'b1;
			end
		end

		if (ctl.exec) begin
			res_valid = 1'b1;
			unique case (cmd_q)
				CMD_ALLOC: begin
					if (!ready_q) begin
						res_status = STAT_NOT_INIT;
					end else if (count_q == '0) begin
						res_status = STAT_EMPTY;
					end else begin
						head_d   = ptr_inc(head_q);
						count_d  = count_q - CW'(1);
						iu_we    = 1'b1;
						iu_waddr = queue_rd_q;
						iu_wdata = 1'b1;
						res_addr = alloc_addr[OADDR_W-1:0];
					end
				end
				CMD_FREE: begin
					if (!ready_q) begin
						res_status = STAT_NOT_INIT;
					end else if ((page_q >= PGW'(eff_total)) || !in_use_rd_q) begin
						res_status = STAT_BAD_FREE;
					end else begin
						iu_we    = 1'b1;
						iu_waddr = page_q[PW-1:0];
						iu_wdata = 1'b0;
						q_we     = 1'b1;
						q_wdata  = page_q[PW-1:0];
						tail_d   = ptr_inc(tail_q);
						count_d  = count_q + CW'(1);
					end
				end
				default: begin
					res_status = STAT_OK;
				end
			endcase
		end

		count_wide = 32'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			ready_q <= 1'b0;
			sweep_q <= '0;
			done_q  <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			ready_q <= ready_d;
			done_q  <= res_valid;
			if (ctl.accept) begin
				sweep_q <= '0;
			end else if (ctl.sweep) begin
				sweep_q <= ptr_inc(sweep_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q  <= command;
			page_q <= free_address[PHYS_W-1:PAGE_SHIFT];
		end
		if (res_valid) begin
			addr_q   <= res_addr;
			status_q <= res_status;
			fcount_q <= count_wide[OCOUNT_W-1:0];
		end
	end

	// In-use bits: read on accept, written by sweep, allocate or free.
	always_ff @(posedge clk) begin
		if (iu_we) begin
			in_use_mem[iu_waddr] <= iu_wdata;
		end
		if (ctl.accept) begin
			in_use_rd_q <= in_use_mem[free_address[PAGE_SHIFT +: PW]];
		end
	end

	// Free queue ring: append at tail, read head on accept.
	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[tail_q] <= q_wdata;
		end
		if (ctl.accept) begin
			queue_rd_q <= queue_mem[head_q];
		end
	end

	assign done         = done_q;
	assign page_address = addr_q;
	assign status       = status_q;
	assign free_count   = fcount_q;

endmodule

[hw/rtl/page_free_list_allocator_top.sv]
// Physical page allocator with a FIFO free list: command interface, config port,
// single result per request.
//
// A request is taken when start is high and busy is low; command selects
// initialize, allocate or free, and free_address gives the page to free.
// Each request produces one result: page_address, status and free_count are
// valid for exactly one cycle while done is high. The receiver cannot stall.
// Allocate and free: the accept edge reads the in-use bit and the queue head,
// and the exec state updates the memories; done follows in the next cycle
// from the result register, and a new request may be accepted while done is
// high. Busy holds off a new request until the exec state is through.
// Initialize sweeps every page, one in-use bit per cycle, and appends each
// page from reserved_pages up to below total_pages to the queue; then done.
// Configuration (cfg_index 0 total_pages, 1 reserved_pages) is always ready
// and must be written only while no request is in flight.
// Reset returns to idle, not initialized; allocate and free report status 3
// until an initialize completes. Memories are not reset; initialize fills them.
`timescale 1ns / 1ps

module page_free_list_allocator_top #(
	parameter int unsigned MAX_PAGES  = 4096,
	parameter int unsigned PAGE_SHIFT = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [pfla_pkg::CMD_W-1:0]      command,
	input  logic [pfla_pkg::ADDR_W-1:0]     free_address,
	output logic                            done,
	output logic [pfla_pkg::OADDR_W-1:0]    page_address,
	output logic [pfla_pkg::STAT_W-1:0]     status,
	output logic [pfla_pkg::OCOUNT_W-1:0]   free_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [pfla_pkg::CFG_W-1:0]      cfg_data
);
	import pfla_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t dp_stat;

	assign cfg_ready = 1'b1;

	pfla_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.dp_stat (dp_stat),
		.ctl     (ctl),
		.busy    (busy)
	);

	pfla_datapath #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.dp_stat      (dp_stat),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.free_address (free_address),
		.done         (done),
		.page_address (page_address),
		.status       (status),
		.free_count   (free_count)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STAT_OK)) |-> (page_address == '0))
		else $error("failed request returned a nonzero page address");

	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.sweep || ctl.exec) |-> busy)
		else $error("datapath working while controller idle");

endmodule

[sim/tb_top.sv]
// Testbench for the page free-list allocator: random and directed commands checked against a model.
`timescale 1ns / 1ps

module tb_top;
	import pfla_pkg::*;

	localparam int unsigned MAX_PAGES     = 4096;
	localparam int unsigned PAGE_SHIFT    = 12;
	localparam int unsigned PAGE_W        = $clog2(MAX_PAGES);
	localparam int unsigned PN_W          = PHYS_W - PAGE_SHIFT;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned QUIET_LIMIT   = 20000;
	localparam int unsigned RANDOM_PHASES = 14;
	localparam int unsigned PHASE_CMDS    = 66;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] addr;
		int unsigned       gap;
	} page_cmd_t;

	typedef struct {
		logic [OADDR_W-1:0]  addr;
		logic [STAT_W-1:0]   stat;
		logic [OCOUNT_W-1:0] count;
	} page_result_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic                busy;
	logic [CMD_W-1:0]    command      = '0;
	logic [ADDR_W-1:0]   free_address = '0;
	logic                done;
	logic [OADDR_W-1:0]  page_address;
	logic [STAT_W-1:0]   status;
	logic [OCOUNT_W-1:0] free_count;
	logic                cfg_valid    = 1'b0;
	logic                cfg_ready;
	logic                cfg_index    = CFG_TOTAL;
	logic [CFG_W-1:0]    cfg_data     = '0;

	// model of the allocator state
	logic [PAGE_W-1:0] ring_pages [MAX_PAGES];
	bit                page_taken [MAX_PAGES];
	int unsigned       ring_head    = 0;
	int unsigned       ring_tail    = 0;
	int unsigned       ring_count   = 0;
	bit                list_ready   = 1'b0;
	logic [CFG_W-1:0]  cfg_total    = 13'd4096;
	logic [CFG_W-1:0]  cfg_reserved = '0;

	int unsigned  held_pages [$];
	page_cmd_t    pending_cmds [$];
	page_result_t pending_results [$];
	int unsigned  mismatches   = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  hold_cnt     = 0;
	int unsigned  cur_gap      = 0;
	bit           no_idle      = 1'b0;

	page_free_list_allocator_top #(
		.MAX_PAGES (MAX_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.free_address(free_address),
		.done        (done),
		.page_address(page_address),
		.status      (status),
		.free_count  (free_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int unsigned page_limit();
		return (cfg_total > MAX_PAGES) ? MAX_PAGES : cfg_total;
	endfunction

	function automatic void ring_push(input int unsigned pg);
		ring_pages[ring_tail] = pg[PAGE_W-1:0];
		ring_tail = (ring_tail + 1) % MAX_PAGES;
		ring_count++;
	endfunction

	function automatic void predict_page_result(input logic [CMD_W-1:0] cmd,
			input logic [ADDR_W-1:0] addr);
		page_result_t    res;
		int unsigned     lim;
		int unsigned     rsv;
		int unsigned     pg;
		int unsigned     i;
		logic [PN_W-1:0] free_pg;
		res.addr = '0;
		res.stat = STAT_OK;
		lim = page_limit();
		rsv = (cfg_reserved > lim) ? lim : cfg_reserved;
		case (cmd)
		CMD_INIT: begin
			ring_head = 0;
			ring_tail = 0;
			ring_count = 0;
			for (i = 0; i < MAX_PAGES; i++) begin
				if (i >= rsv && i < lim) begin
					page_taken[i] = 1'b0;
					ring_push(i);
				end else begin
					page_taken[i] = 1'b1;
				end
			end
			list_ready = 1'b1;
			held_pages.delete();
		end
		CMD_ALLOC: begin
			if (!list_ready) begin
				res.stat = STAT_NOT_INIT;
			end else if (ring_count == 0) begin
				res.stat = STAT_EMPTY;
			end else begin
				pg = ring_pages[ring_head];
				ring_head = (ring_head + 1) % MAX_PAGES;
				ring_count--;
				page_taken[pg] = 1'b1;
				res.addr = OADDR_W'(pg << PAGE_SHIFT);
				held_pages.push_back(pg);
			end
		end
		CMD_FREE: begin
			free_pg = addr[PHYS_W-1:PAGE_SHIFT];
			if (!list_ready) begin
				res.stat = STAT_NOT_INIT;
			end else if (free_pg >= lim || !page_taken[free_pg[PAGE_W-1:0]]) begin
				res.stat = STAT_BAD_FREE;
			end else begin
				page_taken[free_pg[PAGE_W-1:0]] = 1'b0;
				ring_push(free_pg[PAGE_W-1:0]);
			end
		end
		default: begin
		end
		endcase
		res.count = OCOUNT_W'(ring_count);
		pending_results.push_back(res);
	endfunction

	function automatic void note_mismatch(input string msg);
		if (mismatches < 10)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		page_cmd_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			command <= '0;
			free_address <= '0;
			hold_cnt = 0;
			cur_gap = 0;
		end else begin
			if (start && !busy) begin
				predict_page_result(command, free_address);
				hold_cnt = cur_gap;
			end
			if (!start || !busy) begin
				if (hold_cnt != 0) begin
					hold_cnt--;
					start <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					nxt = pending_cmds.pop_front();
					start <= 1'b1;
					command <= nxt.cmd;
					free_address <= nxt.addr;
					cur_gap = nxt.gap;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : result_check
		page_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result addr=%h status=%0d count=%0d",
					page_address, status, free_count));
			end else begin
				want = pending_results.pop_front();
				if (page_address !== want.addr || status !== want.stat ||
						free_count !== want.count)
					note_mismatch($sformatf(
						"expected addr=%h status=%0d count=%0d, got addr=%h status=%0d count=%0d",
						want.addr, want.stat, want.count, page_address, status, free_count));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
		page_cmd_t c;
		while (pending_cmds.size() >= 2)
			@(negedge clk);
		c.cmd = cmd;
		c.addr = addr;
		c.gap = no_idle ? 0 : $urandom_range(0, 9);
		pending_cmds.push_back(c);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || start || pending_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_TOTAL)
			cfg_total = val;
		else
			cfg_reserved = val;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ADDR_W-1:0] page_to_addr(input logic [PN_W-1:0] pg);
		logic [ADDR_W-PHYS_W-1:0] upper;
		upper = $urandom_range(0, 1) ? (ADDR_W-PHYS_W)'($urandom) : '0;
		return {upper, pg, PAGE_SHIFT'($urandom)};
	endfunction

	initial begin : stimulus
		int unsigned preset_total [10] = '{4, 16, 0, 4096, 8191, 64, 32, 200, 4096, 2};
		int unsigned preset_rsv   [10] = '{0, 3, 0, 4000, 100, 64, 8191, 190, 0, 1};
		int unsigned ph;
		int unsigned t;
		int unsigned r;
		int unsigned pick;
		int unsigned idx;
		int unsigned pg;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// before initialize: allocate and free report not initialized
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_FREE, '1);
		queue_cmd(CMD_FREE, '0);
		queue_cmd(CMD_UNUSED, '0);
		queue_cmd(CMD_INIT, '0);
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_ALLOC, '0);
		// upper address bits are masked off
		queue_cmd(CMD_FREE, {16'hFFFF, 36'd0, 12'hFFF});
		queue_cmd(CMD_FREE, 64'd0);
		queue_cmd(CMD_FREE, 64'h0000_0000_0100_0000);
		queue_cmd(CMD_FREE, {16'h0, 36'hF_FFFF_FFFF, 12'h0});
		queue_cmd(CMD_UNUSED, '1);
		wait_idle();

		// single page: allocate until empty
		write_reg(CFG_TOTAL, 13'd1);
		write_reg(CFG_RESERVED, 13'd0);
		queue_cmd(CMD_INIT, '0);
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_FREE, 64'd0);
		queue_cmd(CMD_FREE, 64'd0);
		wait_idle();

		// saturated registers: every page reserved, then hand one back
		write_reg(CFG_TOTAL, 13'h1FFF);
		write_reg(CFG_RESERVED, 13'h1FFF);
		queue_cmd(CMD_INIT, '0);
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_FREE, 64'h0000_0000_00FF_F000);
		queue_cmd(CMD_ALLOC, '0);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 10) begin
				t = preset_total[ph];
				r = preset_rsv[ph];
			end else begin
				t = $urandom_range(0, 8191);
				r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, t);
			end
			wait_idle();
			if ($urandom_range(0, 1)) begin
				write_reg(CFG_TOTAL, t[CFG_W-1:0]);
				write_reg(CFG_RESERVED, r[CFG_W-1:0]);
			end else begin
				write_reg(CFG_RESERVED, r[CFG_W-1:0]);
				write_reg(CFG_TOTAL, t[CFG_W-1:0]);
			end
			// some phases keep the old list under new registers
			if (ph % 5 != 3)
				queue_cmd(CMD_INIT, {$urandom, $urandom});
			repeat (PHASE_CMDS) begin
				if ($urandom_range(0, 19) == 0)
					no_idle = !no_idle;
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					queue_cmd(CMD_INIT, {$urandom, $urandom});
				end else if (pick < 6) begin
					queue_cmd(CMD_UNUSED, {$urandom, $urandom});
				end else if (pick < 50 || (pick < 80 && held_pages.size() == 0)) begin
					queue_cmd(CMD_ALLOC, {$urandom, $urandom});
				end else if (pick < 80) begin
					idx = $urandom_range(0, held_pages.size() - 1);
					pg = held_pages[idx];
					held_pages.delete(idx);
					queue_cmd(CMD_FREE, page_to_addr(PN_W'(pg)));
				end else if (pick < 90) begin
					queue_cmd(CMD_FREE, page_to_addr(PN_W'($urandom_range(0, page_limit() + 3))));
				end else begin
					queue_cmd(CMD_FREE, {$urandom, $urandom});
				end
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
